FILE: hdl/tbms_pkg.sv
// ----------------------------------------------------------------------------
// Two-bank multilevel scheduler package
// Field widths, operation codes and quantum constants shared by the design.
// ----------------------------------------------------------------------------
package tbms_pkg;

  localparam int FIELD_ID_W = 8;
  localparam int QUANT_W    = 5;
  localparam int LVL_CFG_W  = 4;

  localparam logic [LVL_CFG_W-1:0] LEVELS_RESET = 4'd8;

  localparam logic ACT_ADD     = 1'b0;
  localparam logic ACT_RESCHED = 1'b1;

  localparam int QUANTUM_BASE = 10;
  localparam int QUANTUM_STEP = 2;
  localparam int QUANTUM_MAX  = 31;

endpackage

FILE: hdl/tbms_qinfo.sv
// ----------------------------------------------------------------------------
// Queue descriptor table
// Holds head pointer and fill count for every queue of both banks. Entries
// that were never written read as an empty queue. One write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
module tbms_qinfo #(
  parameter int NQ     = 16,
  parameter int ADDR_W = 4,
  parameter int PTR_W  = 4,
  parameter int CNT_W  = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [PTR_W-1:0]  rd_head,
  output logic [CNT_W-1:0]  rd_count,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [PTR_W-1:0]  wr_head,
  input  logic [CNT_W-1:0]  wr_count
);

  logic [NQ-1:0]    vld_r;
  logic             rd_vld_r;
  logic [PTR_W-1:0] head_mem [NQ];
  logic [CNT_W-1:0] cnt_mem [NQ];
  logic [PTR_W-1:0] rd_head_r;
  logic [CNT_W-1:0] rd_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      head_mem[wr_addr] <= wr_head;
      cnt_mem[wr_addr]  <= wr_count;
    end
    rd_head_r <= head_mem[rd_addr];
    rd_cnt_r  <= cnt_mem[rd_addr];
  end

  assign rd_head  = rd_vld_r ? rd_head_r : '0;
  assign rd_count = rd_vld_r ? rd_cnt_r : '0;

endmodule

FILE: hdl/two_bank_multilevel_scheduler.sv
// An add word passes S_ENQ_RD and S_ENQ_CHK, then S_FIN loads its result into
// the output register. A reschedule word hands back an id in those states when
// it has one, scans levels in S_SCAN_RD and S_SCAN_CHK with at most one bank
// swap, reads a grant's id in S_DEQ_WAIT and ends in S_FIN, which waits while
// the output register is stalled. One word is in work at a time; a new word is
// taken in the cycle after the result is loaded into it. Reset is synchronous,
// active low, and clears all queues at once through per-queue valid bits.
// ----------------------------------------------------------------------------
// Two-bank multilevel scheduler
// Active and expired banks of FIFO queues, one queue per level per bank.
// A small sequencer walks the levels one per step through a shared
// descriptor table and a shared id store.
// ----------------------------------------------------------------------------
module two_bank_multilevel_scheduler #(
  parameter int LEVELS      = 8,
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_action,
  input  logic [tbms_pkg::FIELD_ID_W-1:0]  in_new_id,
  input  logic                             in_has_current,
  input  logic [tbms_pkg::FIELD_ID_W-1:0]  in_current_id,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_granted,
  output logic [tbms_pkg::FIELD_ID_W-1:0]  out_granted_id,
  output logic [tbms_pkg::QUANT_W-1:0]     out_quantum,
  output logic                             out_empty_res,
  output logic                             out_overflow,
  input  logic                             cfg_wr_en,
  input  logic [tbms_pkg::LVL_CFG_W-1:0]   cfg_wr_data
);

  localparam int NQ  = 2 * LEVELS;
  localparam int QW  = $clog2(NQ);
  localparam int LW  = $clog2(LEVELS + 1);
  localparam int LW1 = LW + 1;
  localparam int PW  = $clog2(QUEUE_DEPTH);
  localparam int PW1 = PW + 1;
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int NS  = NQ * QUEUE_DEPTH;
  localparam int SW  = $clog2(NS);
  localparam int HW  = $clog2(NS + 1);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_ENQ_RD   = 3'd1;
  localparam logic [2:0] S_ENQ_CHK  = 3'd2;
  localparam logic [2:0] S_SCAN_RD  = 3'd3;
  localparam logic [2:0] S_SCAN_CHK = 3'd4;
  localparam logic [2:0] S_DEQ_WAIT = 3'd5;
  localparam logic [2:0] S_FIN      = 3'd6;

  function automatic logic [QW-1:0] qidx(input logic b, input logic [LW-1:0] l);
    return QW'(b) * QW'(LEVELS) + QW'(l);
  endfunction

  function automatic logic [SW-1:0] sidx(input logic [QW-1:0] q, input logic [PW-1:0] s);
    return SW'(q) * SW'(QUEUE_DEPTH) + SW'(s);
  endfunction

  logic [2:0]                         state_r, state_nxt;
  logic [tbms_pkg::LVL_CFG_W-1:0]     levels_r, levels_nxt;
  logic                               act_r, act_nxt;
  logic [ID_BITS-1:0]                 id_r, id_nxt;
  logic [LW-1:0]                      eff_l_r, eff_l_nxt;
  logic                               bank_r, bank_nxt;
  logic [LW-1:0]                      last_r, last_nxt;
  logic                               swapped_r, swapped_nxt;
  logic [QW-1:0]                      tgt_q_r, tgt_q_nxt;
  logic [HW-1:0]                      held_r, held_nxt;
  logic                               granted_r, granted_nxt;
  logic [tbms_pkg::FIELD_ID_W-1:0]    gid_r, gid_nxt;
  logic [tbms_pkg::QUANT_W-1:0]       quant_r, quant_nxt;
  logic                               ovf_r, ovf_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic                               o_granted_r, o_granted_nxt;
  logic [tbms_pkg::FIELD_ID_W-1:0]    o_gid_r, o_gid_nxt;
  logic [tbms_pkg::QUANT_W-1:0]       o_quant_r, o_quant_nxt;
  logic                               o_empty_r, o_empty_nxt;
  logic                               o_ovf_r, o_ovf_nxt;

  logic [LW-1:0]      eff_l;
  logic [LW1-1:0]     lvl_p1;
  logic [LW1-1:0]     lvl_max;
  logic [LW-1:0]      dem_lvl;
  logic [PW1-1:0]     slot_sum;
  logic [PW-1:0]      slot;
  logic [PW1-1:0]     head_p1;
  logic [PW-1:0]      head_inc;
  logic [LW-1:0]      lvl_diff;
  logic [7:0]         quant_raw;
  logic [tbms_pkg::QUANT_W-1:0] quant;

  logic [QW-1:0]      qi_rd_addr;
  logic [PW-1:0]      qi_head;
  logic [CW-1:0]      qi_cnt;
  logic               qi_we;
  logic [PW-1:0]      qi_wh;
  logic [CW-1:0]      qi_wc;

  logic [ID_BITS-1:0] store_mem [NS];
  logic [ID_BITS-1:0] store_q;
  logic               st_we;
  logic [SW-1:0]      st_wa;
  logic [SW-1:0]      st_ra;

  tbms_qinfo #(
    .NQ     (NQ),
    .ADDR_W (QW),
    .PTR_W  (PW),
    .CNT_W  (CW)
  ) u_qinfo (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_addr  (qi_rd_addr),
    .rd_head  (qi_head),
    .rd_count (qi_cnt),
    .wr_en    (qi_we),
    .wr_addr  (tgt_q_r),
    .wr_head  (qi_wh),
    .wr_count (qi_wc)
  );

  always_ff @(posedge clk) begin
    if (st_we) begin
      store_mem[st_wa] <= id_r;
    end
    store_q <= store_mem[st_ra];
  end

  always_comb begin
    if (levels_r == '0) begin
      eff_l = LW'(1);
    end else if (int'(levels_r) > LEVELS) begin
      eff_l = LW'(LEVELS);
    end else begin
      eff_l = LW'(levels_r);
    end
    lvl_p1  = LW1'(last_r) + LW1'(1);
    lvl_max = LW1'(eff_l) - LW1'(1);
    dem_lvl = (lvl_p1 > lvl_max) ? lvl_max[LW-1:0] : lvl_p1[LW-1:0];

    slot_sum = PW1'(qi_head) + PW1'(qi_cnt);
    slot     = (slot_sum >= PW1'(QUEUE_DEPTH)) ?
               PW'(slot_sum - PW1'(QUEUE_DEPTH)) : slot_sum[PW-1:0];
    head_p1  = PW1'(qi_head) + PW1'(1);
    head_inc = (head_p1 == PW1'(QUEUE_DEPTH)) ? '0 : head_p1[PW-1:0];

    lvl_diff  = eff_l_r - last_r;
    quant_raw = 8'(lvl_diff) * 8'(tbms_pkg::QUANTUM_STEP) + 8'(tbms_pkg::QUANTUM_BASE);
    quant     = (quant_raw > 8'(tbms_pkg::QUANTUM_MAX)) ?
                tbms_pkg::QUANT_W'(tbms_pkg::QUANTUM_MAX) :
                quant_raw[tbms_pkg::QUANT_W-1:0];
  end

  always_comb begin
    state_nxt     = state_r;
    levels_nxt    = levels_r;
    act_nxt       = act_r;
    id_nxt        = id_r;
    eff_l_nxt     = eff_l_r;
    bank_nxt      = bank_r;
    last_nxt      = last_r;
    swapped_nxt   = swapped_r;
    tgt_q_nxt     = tgt_q_r;
    held_nxt      = held_r;
    granted_nxt   = granted_r;
    gid_nxt       = gid_r;
    quant_nxt     = quant_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r;
    o_granted_nxt = o_granted_r;
    o_gid_nxt     = o_gid_r;
    o_quant_nxt   = o_quant_r;
    o_empty_nxt   = o_empty_r;
    o_ovf_nxt     = o_ovf_r;
    qi_rd_addr    = '0;
    qi_we         = 1'b0;
    qi_wh         = qi_head;
    qi_wc         = qi_cnt;
    st_we         = 1'b0;
    st_wa         = sidx(tgt_q_r, slot);
    st_ra         = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cfg_wr_en) begin
      levels_nxt = cfg_wr_data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          act_nxt     = in_action;
          eff_l_nxt   = eff_l;
          swapped_nxt = 1'b0;
          granted_nxt = 1'b0;
          gid_nxt     = '0;
          quant_nxt   = '0;
          ovf_nxt     = 1'b0;
          if (in_action == tbms_pkg::ACT_ADD) begin
            id_nxt    = ID_BITS'(in_new_id);
            tgt_q_nxt = qidx(bank_r, LW'(0));
            state_nxt = S_ENQ_RD;
          end else if (in_has_current) begin
            id_nxt    = ID_BITS'(in_current_id);
            tgt_q_nxt = qidx(~bank_r, dem_lvl);
            state_nxt = S_ENQ_RD;
          end else begin
            state_nxt = S_SCAN_RD;
          end
        end
      end
      S_ENQ_RD: begin
        qi_rd_addr = tgt_q_r;
        state_nxt  = S_ENQ_CHK;
      end
      S_ENQ_CHK: begin
        if (qi_cnt == CW'(QUEUE_DEPTH)) begin
          ovf_nxt = 1'b1;
        end else begin
          st_we    = 1'b1;
          qi_we    = 1'b1;
          qi_wc    = qi_cnt + CW'(1);
          held_nxt = held_r + HW'(1);
        end
        state_nxt = (act_r == tbms_pkg::ACT_ADD) ? S_FIN : S_SCAN_RD;
      end
      S_SCAN_RD: begin
        if (last_r < eff_l_r) begin
          qi_rd_addr = qidx(bank_r, last_r);
          tgt_q_nxt  = qidx(bank_r, last_r);
          state_nxt  = S_SCAN_CHK;
        end else if (!swapped_r) begin
          bank_nxt    = ~bank_r;
          last_nxt    = '0;
          swapped_nxt = 1'b1;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_SCAN_CHK: begin
        if (qi_cnt != '0) begin
          st_ra       = sidx(tgt_q_r, qi_head);
          qi_we       = 1'b1;
          qi_wh       = head_inc;
          qi_wc       = qi_cnt - CW'(1);
          held_nxt    = held_r - HW'(1);
          granted_nxt = 1'b1;
          quant_nxt   = quant;
          state_nxt   = S_DEQ_WAIT;
        end else begin
          last_nxt  = last_r + LW'(1);
          state_nxt = S_SCAN_RD;
        end
      end
      S_DEQ_WAIT: begin
        gid_nxt   = tbms_pkg::FIELD_ID_W'(store_q);
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          o_granted_nxt = granted_r;
          o_gid_nxt     = gid_r;
          o_quant_nxt   = quant_r;
          o_empty_nxt   = (held_r == '0);
          o_ovf_nxt     = ovf_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      levels_r    <= tbms_pkg::LEVELS_RESET;
      bank_r      <= 1'b0;
      last_r      <= '0;
      held_r      <= '0;
      swapped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      levels_r    <= levels_nxt;
      bank_r      <= bank_nxt;
      last_r      <= last_nxt;
      held_r      <= held_nxt;
      swapped_r   <= swapped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r       <= act_nxt;
    id_r        <= id_nxt;
    eff_l_r     <= eff_l_nxt;
    tgt_q_r     <= tgt_q_nxt;
    granted_r   <= granted_nxt;
    gid_r       <= gid_nxt;
    quant_r     <= quant_nxt;
    ovf_r       <= ovf_nxt;
    o_granted_r <= o_granted_nxt;
    o_gid_r     <= o_gid_nxt;
    o_quant_r   <= o_quant_nxt;
    o_empty_r   <= o_empty_nxt;
    o_ovf_r     <= o_ovf_nxt;
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_granted    = o_granted_r;
  assign out_granted_id = o_gid_r;
  assign out_quantum    = o_quant_r;
  assign out_empty_res  = o_empty_r;
  assign out_overflow   = o_ovf_r;

endmodule
